FILE: sv/complex_beamformer_mac_top_defines.svh
// ----------------------------------------------------------------------------
// complex_beamformer_mac_top_defines.svh
// assertion macros for the beamformer rtl
// ----------------------------------------------------------------------------
`ifndef COMPLEX_BEAMFORMER_MAC_TOP_DEFINES_SVH
`define COMPLEX_BEAMFORMER_MAC_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge outside reset
`define CBM_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbm assertion failed");

// condition in one cycle implies a result in the next
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("cbm assertion failed");

`else

`define CBM_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define CBM_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)

`endif

`endif

FILE: sv/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// constants, types and helpers of the complex beamformer mac
// ----------------------------------------------------------------------------
package cbm_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int NUM_BEAMS    = 3;
    localparam int SAMPLE_BITS  = 16;

    // fixed field widths
    localparam int BEAM_SEL_W = 2;
    localparam int CHAN_SEL_W = 4;
    localparam int VALUE_W    = 16;
    localparam int BEAM_NUM_W = 2;
    localparam int OUT_SUM_W  = 38;

    localparam int IN_RAW_W    = BEAM_SEL_W + CHAN_SEL_W + 2 * VALUE_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = BEAM_NUM_W + 2 * OUT_SUM_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RAW_W;

    localparam int CH_W       = $clog2(NUM_CHANNELS);
    localparam int BEAM_IDX_W = (NUM_BEAMS > 1) ? $clog2(NUM_BEAMS) : 1;
    localparam int WEIGHT_W   = 2 * SAMPLE_BITS;
    localparam int PROD_W     = 2 * SAMPLE_BITS;
    localparam int TERM_W     = PROD_W + 1;
    localparam int ACC_W      = TERM_W + CH_W;

    // request kinds carried in tuser
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [TERM_W-1:0]      t_term;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [OUT_SUM_W-1:0]   t_sum;
    typedef logic [CH_W-1:0]               t_chan;
    typedef logic [BEAM_IDX_W-1:0]         t_beam_idx;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_stage_ctl;

    // low SAMPLE_BITS of the raw field, two's complement
    function automatic t_sample to_sample(logic [VALUE_W-1:0] raw);
        return t_sample'({{SAMPLE_BITS{1'b0}}, raw});
    endfunction

    // clamp an accumulator to the output range
    function automatic t_sum sat_sum(t_acc v);
        logic signed [63:0] w;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        w  = 64'(v);
        hi = (64'sd1 <<< (OUT_SUM_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (w > hi) begin
            return t_sum'(hi);
        end else if (w < lo) begin
            return t_sum'(lo);
        end
        return t_sum'(w);
    endfunction

endpackage

FILE: sv/complex_beamformer_mac_top.sv
// ----------------------------------------------------------------------------
// complex_beamformer_mac_top
// narrowband complex-weight beamformer: per-beam complex dot product
// ----------------------------------------------------------------------------
// The block takes one item per clock while o_s_tready is high. A weight-load
// item (tuser 0) writes one complex weight into the weight ram of its beam at
// its channel; a load whose beam or channel is out of range is dropped. A
// sample item (tuser 1) carries one channel's complex value, channels in order
// 0 to NUM_CHANNELS-1; every beam multiplies it by its weight for the current
// channel and accumulates. The last channel of a sample makes NUM_BEAMS
// results, in beam order, the last one flagged by tlast; they leave one per
// cycle from a result bank while i_m_tready is high. The last channel's item
// reaches the bank through the weight ram read, the multiplier stage and the
// accumulate stage. Input ready drops only while a sample's last channel waits
// in the accumulate stage and the previous sample's results still fill the
// bank; it rises again in the cycle after the last of those results has left.
// Weights must be loaded before they are used; loads may arrive between
// channels and take effect from the next sample item on.
// ----------------------------------------------------------------------------
`include "complex_beamformer_mac_top_defines.svh"

module complex_beamformer_mac_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // beam_select[1:0], channel_select[5:2], value_i[21:6], value_q[37:22]
    input  logic [cbm_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // req_type[0]
    input  logic                            i_s_tuser,
    // result items
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // beam_number[1:0], beam_i[39:2], beam_q[77:40]
    output logic [cbm_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // last_beam
    output logic                            o_m_tlast
);

    import cbm_pkg::*;

    // input field unpacking
    logic [BEAM_SEL_W-1:0] w_beam_sel;
    logic [CHAN_SEL_W-1:0] w_chan_sel;
    logic [VALUE_W-1:0]    w_val_i_raw;
    logic [VALUE_W-1:0]    w_val_q_raw;
    t_sample               w_val_i;
    t_sample               w_val_q;

    assign w_beam_sel  = i_s_tdata[0 +: BEAM_SEL_W];
    assign w_chan_sel  = i_s_tdata[BEAM_SEL_W +: CHAN_SEL_W];
    assign w_val_i_raw = i_s_tdata[BEAM_SEL_W + CHAN_SEL_W +: VALUE_W];
    assign w_val_q_raw = i_s_tdata[BEAM_SEL_W + CHAN_SEL_W + VALUE_W +: VALUE_W];
    assign w_val_i     = to_sample(w_val_i_raw);
    assign w_val_q     = to_sample(w_val_q_raw);

    // pipeline control
    t_stage_ctl r_s1_ctl;
    t_stage_ctl r_s2_ctl;
    t_sample    r_s1_vi;
    t_sample    r_s1_vq;
    t_chan      r_chan_cnt;

    // result bank
    logic       r_snap_valid;
    t_beam_idx  r_drain;
    t_sum       r_snap_i [NUM_BEAMS];
    t_sum       r_snap_q [NUM_BEAMS];

    logic w_adv;
    logic w_in_fire;
    logic w_sample_fire;
    logic w_load_fire;
    logic w_chan_last;
    t_chan w_wr_addr;

    // stall only while a finished sample cannot enter an occupied bank
    assign w_adv         = !(r_s2_ctl.valid && r_s2_ctl.last && r_snap_valid);
    assign o_s_tready    = w_adv;
    assign w_in_fire     = i_s_tvalid && w_adv;
    assign w_sample_fire = w_in_fire && (i_s_tuser == REQ_SAMPLE);
    assign w_load_fire   = w_in_fire && (i_s_tuser == REQ_LOAD)
                           && (int'(w_beam_sel) < NUM_BEAMS)
                           && (int'(w_chan_sel) < NUM_CHANNELS);
    assign w_chan_last   = (r_chan_cnt == CH_W'(NUM_CHANNELS - 1));
    assign w_wr_addr     = CH_W'({{CH_W{1'b0}}, w_chan_sel});

    // per-beam weight ram, products and accumulator
    logic [WEIGHT_W-1:0] w_wdata [NUM_BEAMS];
    t_sample w_wi   [NUM_BEAMS];
    t_sample w_wq   [NUM_BEAMS];
    t_prod   r_p_ii [NUM_BEAMS];
    t_prod   r_p_qq [NUM_BEAMS];
    t_prod   r_p_iq [NUM_BEAMS];
    t_prod   r_p_qi [NUM_BEAMS];
    t_term   w_term_i [NUM_BEAMS];
    t_term   w_term_q [NUM_BEAMS];
    t_acc    n_acc_i  [NUM_BEAMS];
    t_acc    n_acc_q  [NUM_BEAMS];
    t_acc    r_acc_i  [NUM_BEAMS];
    t_acc    r_acc_q  [NUM_BEAMS];

    for (genvar b = 0; b < NUM_BEAMS; b++) begin : g_beam
        // weight entry packed as {q, i}
        cbm_ram #(
            .WIDTH (WEIGHT_W),
            .DEPTH (NUM_CHANNELS)
        ) u_wram (
            .i_clk     (i_clk),
            .i_wr_en   (w_load_fire && (int'(w_beam_sel) == b)),
            .i_wr_addr (w_wr_addr),
            .i_wr_data ({w_val_q, w_val_i}),
            .i_rd_en   (w_sample_fire),
            .i_rd_addr (r_chan_cnt),
            .o_rd_data (w_wdata[b])
        );

        assign w_wi[b] = t_sample'(w_wdata[b][0 +: SAMPLE_BITS]);
        assign w_wq[b] = t_sample'(w_wdata[b][SAMPLE_BITS +: SAMPLE_BITS]);

        // complex product terms, then accumulate or restart on channel 0
        always_comb begin
            w_term_i[b] = t_term'(r_p_ii[b]) - t_term'(r_p_qq[b]);
            w_term_q[b] = t_term'(r_p_iq[b]) + t_term'(r_p_qi[b]);
            if (r_s2_ctl.first) begin
                n_acc_i[b] = t_acc'(w_term_i[b]);
                n_acc_q[b] = t_acc'(w_term_q[b]);
            end else begin
                n_acc_i[b] = r_acc_i[b] + t_acc'(w_term_i[b]);
                n_acc_q[b] = r_acc_q[b] + t_acc'(w_term_q[b]);
            end
        end

        // multiplier stage, aligned with the ram read data
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_p_ii[b] <= r_s1_vi * w_wi[b];
                r_p_qq[b] <= r_s1_vq * w_wq[b];
                r_p_iq[b] <= r_s1_vi * w_wq[b];
                r_p_qi[b] <= r_s1_vq * w_wi[b];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc_i[b] <= '0;
                r_acc_q[b] <= '0;
            end else if (w_adv && r_s2_ctl.valid) begin
                r_acc_i[b] <= n_acc_i[b];
                r_acc_q[b] <= n_acc_q[b];
            end
        end

        // snapshot the finished sums into the bank
        always_ff @(posedge i_clk) begin
            if (w_adv && r_s2_ctl.valid && r_s2_ctl.last) begin
                r_snap_i[b] <= sat_sum(n_acc_i[b]);
                r_snap_q[b] <= sat_sum(n_acc_q[b]);
            end
        end
    end

    // sample values travel beside the ram read
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_vi <= w_val_i;
            r_s1_vq <= w_val_q;
        end
    end

    // stage control and channel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl   <= '0;
            r_s2_ctl   <= '0;
            r_chan_cnt <= '0;
        end else begin
            if (w_adv) begin
                r_s1_ctl.valid <= w_sample_fire;
                r_s1_ctl.first <= (r_chan_cnt == '0);
                r_s1_ctl.last  <= w_chan_last;
                r_s2_ctl       <= r_s1_ctl;
            end
            if (w_sample_fire) begin
                r_chan_cnt <= w_chan_last ? '0 : r_chan_cnt + CH_W'(1);
            end
        end
    end

    // result bank drains one beam per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_drain      <= '0;
        end else if (!r_snap_valid) begin
            if (r_s2_ctl.valid && r_s2_ctl.last) begin
                r_snap_valid <= 1'b1;
                r_drain      <= '0;
            end
        end else if (i_m_tready) begin
            if (r_drain == BEAM_IDX_W'(NUM_BEAMS - 1)) begin
                r_snap_valid <= 1'b0;
            end else begin
                r_drain <= r_drain + BEAM_IDX_W'(1);
            end
        end
    end

    assign o_m_tvalid = r_snap_valid;
    assign o_m_tlast  = (r_drain == BEAM_IDX_W'(NUM_BEAMS - 1));
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_snap_q[r_drain], r_snap_i[r_drain],
                         BEAM_NUM_W'(r_drain)};

    // counter restarts after the last channel of a sample
    `CBM_ASSERT_NEXT(a_chan_wrap, i_clk, i_rst_n, w_sample_fire && w_chan_last, r_chan_cnt == '0)
    // a freshly filled bank starts at beam zero
    `CBM_ASSERT_IMPL(a_bank_start, i_clk, i_rst_n, $rose(r_snap_valid) |-> r_drain == '0)
    // a stall freezes the accumulate stage
    `CBM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_adv, r_s2_ctl == $past(r_s2_ctl))

endmodule

FILE: sv/cbm_ram.sv
// ----------------------------------------------------------------------------
// cbm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
